[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SEDF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define SEDF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/sedf_pkg.sv]
// ---------------------------------------------------------------------------
// sedf_pkg
// Shared types and constants of the start/end byte frame deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sedf_pkg;

  localparam int unsigned MAX_WORDS_DEF = 16;

  localparam logic [7:0] START_BYTE_RST = 8'd1;
  localparam logic [7:0] END_BYTE_RST   = 8'd23;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_IDX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_IDX   = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic store_byte;
    logic close;
    logic rd_issue;
    logic load_word;
    logic next_word;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_end;
    logic close_data;
    logic out_free;
    logic last_word;
  } dp_status_t;

endpackage

[design/sedf_ctrl.sv]
// ---------------------------------------------------------------------------
// sedf_ctrl
// Frame state machine: opens and closes frames and sequences word output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sedf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sedf_pkg::dp_status_t   status_i,
  output sedf_pkg::ctrl_cmd_t    cmd_o
);

  sedf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sedf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b0;
    unique case (state_q)
      sedf_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.is_start) begin
          state_d = sedf_pkg::ST_COLLECT;
        end
      end
      sedf_pkg::ST_COLLECT: begin
        // hold a closing byte until the output register can take a result
        in_stall_o = status_i.is_end && !status_i.out_free;
        if (in_valid_i && !in_stall_o) begin
          if (status_i.is_end) begin
            cmd_o.close = 1'b1;
            state_d     = status_i.close_data ? sedf_pkg::ST_READ : sedf_pkg::ST_IDLE;
          end else begin
            cmd_o.store_byte = 1'b1;
          end
        end
      end
      sedf_pkg::ST_READ: begin
        in_stall_o     = 1'b1;
        cmd_o.rd_issue = 1'b1;
        state_d        = sedf_pkg::ST_LOAD;
      end
      sedf_pkg::ST_LOAD: begin
        in_stall_o = 1'b1;
        if (status_i.out_free) begin
          cmd_o.load_word = 1'b1;
          if (status_i.last_word) begin
            state_d = sedf_pkg::ST_IDLE;
          end else begin
            cmd_o.next_word = 1'b1;
            state_d         = sedf_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = sedf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/sedf_datapath.sv]
// ---------------------------------------------------------------------------
// sedf_datapath
// Config registers, frame counters, word store and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sedf_datapath #(
  parameter int unsigned MAX_WORDS = sedf_pkg::MAX_WORDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [sedf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic [7:0]                     in_byte_i,
  input  sedf_pkg::ctrl_cmd_t            cmd_i,
  output sedf_pkg::dp_status_t           status_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     packet_id_o,
  output logic [4:0]                     word_count_o,
  output logic [3:0]                     word_index_o,
  output logic [31:0]                    data_word_o,
  output logic                           last_o
);

  localparam int unsigned STORE_DEPTH = 2 + 4 * MAX_WORDS;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [7:0]      start_q, start_d, end_q, end_d;
  logic [CW-1:0]   bc_q, bc_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      id_q, id_d, n_q, n_d;
  logic [23:0]     asm_q, asm_d;
  logic [AW-1:0]   wc_q, wc_d;
  logic [31:0]     rdata_q;
  logic [31:0]     mem [MAX_WORDS];

  logic            out_valid_q, out_valid_d;
  sedf_pkg::kind_e kind_q, kind_d;
  logic [7:0]      pid_q, pid_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [3:0]      idx_q, idx_d;
  logic [31:0]     word_q, word_d;
  logic            last_q, last_d;

  logic [CW-1:0]   pay;
  logic [1:0]      lane;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;
  logic [9:0]      pay10;
  logic            bad;
  logic            out_free;
  logic [31:0]     wc_ext;

  assign pay     = bc_q - CW'(2);
  assign lane    = pay[1:0];
  assign wr_addr = AW'(pay[CW-1:2]);
  assign wr_en   = cmd_i.store_byte && (bc_q != CW'(STORE_DEPTH)) && (bc_q >= CW'(2))
                   && (lane == 2'd3);
  assign pay10   = 10'(bc_q) - 10'd2;
  assign bad     = ovf_q || (bc_q < CW'(2)) || (n_q > 8'(MAX_WORDS))
                   || (pay10 != {n_q, 2'b00});
  assign out_free = !out_valid_q || !out_stall_i;
  assign wc_ext   = 32'(wc_q);

  assign status_o.is_start   = (in_byte_i == start_q);
  assign status_o.is_end     = (in_byte_i == end_q);
  assign status_o.close_data = !bad && (n_q != 8'd0);
  assign status_o.out_free   = out_free;
  assign status_o.last_word  = ((8'(wc_q) + 8'd1) == n_q);

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sedf_pkg::CFG_START_IDX: start_d = cfg_data_i;
        sedf_pkg::CFG_END_IDX:   end_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    bc_d  = bc_q;
    ovf_d = ovf_q;
    id_d  = id_q;
    n_d   = n_q;
    asm_d = asm_q;
    wc_d  = wc_q;
    if (cmd_i.store_byte) begin
      if (bc_q == CW'(STORE_DEPTH)) begin
        // drop the byte, frame is reported as an error on close
        ovf_d = 1'b1;
      end else begin
        bc_d = bc_q + CW'(1);
        if (bc_q == CW'(0)) begin
          id_d = in_byte_i;
        end else if (bc_q == CW'(1)) begin
          n_d = in_byte_i;
        end else begin
          unique case (lane)
            2'd0:    asm_d[7:0]   = in_byte_i;
            2'd1:    asm_d[15:8]  = in_byte_i;
            2'd2:    asm_d[23:16] = in_byte_i;
            default: ;
          endcase
        end
      end
    end
    if (cmd_i.close) begin
      bc_d  = '0;
      ovf_d = 1'b0;
      wc_d  = '0;
    end else if (cmd_i.next_word) begin
      wc_d = wc_q + AW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    pid_d       = pid_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    word_d      = word_q;
    last_d      = last_q;
    if (cmd_i.close && bad) begin
      out_valid_d = 1'b1;
      kind_d      = sedf_pkg::KIND_ERROR;
      pid_d       = (bc_q != CW'(0)) ? id_q : 8'd0;
      cnt_d       = 5'd0;
      idx_d       = 4'd0;
      word_d      = 32'd0;
      last_d      = 1'b1;
    end else if (cmd_i.close && (n_q == 8'd0)) begin
      out_valid_d = 1'b1;
      kind_d      = sedf_pkg::KIND_EMPTY;
      pid_d       = id_q;
      cnt_d       = 5'd0;
      idx_d       = 4'd0;
      word_d      = 32'd0;
      last_d      = 1'b1;
    end else if (cmd_i.load_word) begin
      out_valid_d = 1'b1;
      kind_d      = sedf_pkg::KIND_DATA;
      pid_d       = id_q;
      cnt_d       = n_q[4:0];
      idx_d       = wc_ext[3:0];
      word_d      = rdata_q;
      last_d      = status_o.last_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= sedf_pkg::START_BYTE_RST;
      end_q       <= sedf_pkg::END_BYTE_RST;
      bc_q        <= '0;
      ovf_q       <= 1'b0;
      wc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_q     <= start_d;
      end_q       <= end_d;
      bc_q        <= bc_d;
      ovf_q       <= ovf_d;
      wc_q        <= wc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    n_q    <= n_d;
    asm_q  <= asm_d;
    kind_q <= kind_d;
    pid_q  <= pid_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    word_q <= word_d;
    last_q <= last_d;
  end

  // word store: one write per completed word, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_byte_i, asm_q};
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[wc_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign packet_id_o  = pid_q;
  assign word_count_o = cnt_q;
  assign word_index_o = idx_q;
  assign data_word_o  = word_q;
  assign last_o       = last_q;

endmodule

[design/soh_etb_frame_deframer.sv]
// ---------------------------------------------------------------------------
// soh_etb_frame_deframer
// Start/end byte framed packet deframer, one received byte per transfer.
// ---------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one byte per transfer. While
// idle a start byte opens a frame; while collecting the end byte closes it and
// every other byte is stored. Byte 0 is the packet id, byte 1 the word count.
// Output channel: out_valid_o / out_stall_i carry one result per transfer:
// data words (little-endian), an empty packet, or an error, last_o on the
// final result of a frame.
// Config port: cfg_valid_i / cfg_ready_o write start byte (index 0) or end
// byte (index 1); ready is always high.
// Throughput: one byte per cycle while a frame is collected. A good frame of
// n words emits its words one by one, each read from the word store and then
// loaded into the output register, and stalls the input meanwhile. Error and
// empty results appear in the cycle after the end byte is accepted.
// A stalled receiver holds the output register; a closing byte then stalls
// until the pending result transfers. Other bytes keep flowing.
// Reset: idle, counters cleared, start byte 1, end byte 23, no output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module soh_etb_frame_deframer #(
  parameter int unsigned MAX_WORDS = sedf_pkg::MAX_WORDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sedf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     packet_id_o,
  output logic [4:0]                     word_count_o,
  output logic [3:0]                     word_index_o,
  output logic [31:0]                    data_word_o,
  output logic                           last_o
);

  sedf_pkg::ctrl_cmd_t  cmd;
  sedf_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  sedf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sedf_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (in_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .packet_id_o  (packet_id_o),
    .word_count_o (word_count_o),
    .word_index_o (word_index_o),
    .data_word_o  (data_word_o),
    .last_o       (last_o)
  );

endmodule

[design/sedf_checker.sv]
// ---------------------------------------------------------------------------
// sedf_checker
// Port-level assertions for the deframer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sedf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [1:0]  kind_i,
  input logic [4:0]  word_count_i,
  input logic [3:0]  word_index_i,
  input logic [31:0] data_word_i,
  input logic        last_i
);

  `SEDF_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !out_valid_i, "output valid after reset")

  `SEDF_ASSERT(a_error_shape, clk_i, rst_ni, (out_valid_i && kind_i == sedf_pkg::KIND_ERROR) |-> (last_i && word_count_i == 5'd0 && word_index_i == 4'd0 && data_word_i == 32'd0), "malformed error result")

  `SEDF_ASSERT(a_empty_shape, clk_i, rst_ni, (out_valid_i && kind_i == sedf_pkg::KIND_EMPTY) |-> (last_i && word_count_i == 5'd0 && word_index_i == 4'd0 && data_word_i == 32'd0), "malformed empty result")

  `SEDF_ASSERT(a_last_word_index, clk_i, rst_ni, (out_valid_i && kind_i == sedf_pkg::KIND_DATA && last_i) |-> ((word_index_i + 4'd1) == word_count_i[3:0]), "last flag on wrong word")

  `SEDF_ASSERT(a_stall_holds, clk_i, rst_ni, (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(data_word_i) && $stable(kind_i) && $stable(last_i)), "stalled result changed")

endmodule

bind soh_etb_frame_deframer sedf_checker u_sedf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_i       (kind_o),
  .word_count_i (word_count_o),
  .word_index_i (word_index_o),
  .data_word_i  (data_word_o),
  .last_i       (last_o)
);
